// ===== rtl/rgb_to_ycbcr422_alpha_pixel_writer_assert.svh =====
// Assertion macros for the pixel writer RTL (used by rgbycc_ser).
`ifndef RGB_TO_YCBCR422_ALPHA_PIXEL_WRITER_ASSERT_SVH
`define RGB_TO_YCBCR422_ALPHA_PIXEL_WRITER_ASSERT_SVH

// Checked only out of reset.
`define RGBYCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RGBYCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rgbycc_pkg.sv =====
package rgbycc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int STRIDE_W       = 16;
    localparam int ADDR_W         = 28;
    localparam int BYTE_W         = 8;
    localparam int PRD_W          = 24;
    localparam int CSUM_W         = 26;
    localparam int FRAC           = 16;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd5760;

    localparam logic [PRD_W-1:0] K_Y_R  = 24'd19595;
    localparam logic [PRD_W-1:0] K_Y_G  = 24'd38470;
    localparam logic [PRD_W-1:0] K_Y_B  = 24'd7471;
    localparam logic [PRD_W-1:0] K_CB_R = 24'd11076;
    localparam logic [PRD_W-1:0] K_CB_G = 24'd21692;
    localparam logic [PRD_W-1:0] K_HALF = 24'd32768;
    localparam logic [PRD_W-1:0] K_CR_G = 24'd27460;
    localparam logic [PRD_W-1:0] K_CR_B = 24'd5308;
    localparam logic [CSUM_W-1:0] K_C_OFF = 26'd8388608;

    localparam logic [ADDR_W-1:0] ADDR_ONE   = 28'd1;
    localparam logic [ADDR_W-1:0] ADDR_TWO   = 28'd2;
    localparam logic [ADDR_W-1:0] ADDR_THREE = 28'd3;

    typedef enum logic [1:0] {
        SLOT_LUMA  = 2'd0,
        SLOT_ALPHA = 2'd1,
        SLOT_CB    = 2'd2,
        SLOT_CR    = 2'd3
    } t_slot;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_y;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_cb;
        logic [ADDR_W-1:0] addr_cr;
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] cr;
    } t_wr_set;

endpackage

// ===== rtl/rgbycc_if.sv =====
interface rgbycc_pix_if #(
    parameter int COORD_BITS = rgbycc_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            opacity;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, opacity, input ready);
    modport sink (input valid, pixel_x, pixel_y, red, green, blue, opacity, output ready);
endinterface

interface rgbycc_wr_if;
    logic                          valid;
    logic                          ready;
    logic [rgbycc_pkg::ADDR_W-1:0] byte_address;
    logic [rgbycc_pkg::BYTE_W-1:0] byte_value;
    logic                          last_write;

    modport source (output valid, byte_address, byte_value, last_write, input ready);
    modport sink (input valid, byte_address, byte_value, last_write, output ready);
endinterface

// ===== rtl/rgbycc_conv.sv =====
module rgbycc_conv #(
    parameter int COORD_BITS = rgbycc_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rgbycc_pix_if.sink                      i_pix,
    input  logic [rgbycc_pkg::STRIDE_W-1:0] i_stride,
    output logic                            o_valid,
    input  logic                            i_ready,
    output rgbycc_pkg::t_wr_set             o_set
);
    import rgbycc_pkg::*;

    localparam int PROD_W = COORD_BITS + STRIDE_W;
    localparam int X3_W   = COORD_BITS + 2;

    // stage 1: products
    logic              r_v1;
    logic [PROD_W-1:0] r_row;
    logic [X3_W-1:0]   r_x3;
    logic [X3_W-1:0]   r_ev3;
    logic [PRD_W-1:0]  r_yr, r_yg, r_yb;
    logic [PRD_W-1:0]  r_cbr, r_cbg, r_half_b;
    logic [PRD_W-1:0]  r_half_r, r_crg, r_crb;
    logic [BYTE_W-1:0] r_a1;

    // stage 2: sums
    logic              r_v2;
    t_wr_set           r_set;

    logic              adv1, adv2;
    logic [X3_W-1:0]   n_x3;
    logic [ADDR_W-1:0] row;
    logic [CSUM_W-1:0] sum_y, sum_cb, sum_cr;

    assign adv2        = !r_v2 || i_ready;
    assign adv1        = !r_v1 || adv2;
    assign i_pix.ready = adv1;

    assign n_x3 = X3_W'({i_pix.pixel_x, 1'b0}) + X3_W'(i_pix.pixel_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_row    <= PROD_W'(i_pix.pixel_y) * PROD_W'(i_stride);
            r_x3     <= n_x3;
            r_ev3    <= n_x3 - (i_pix.pixel_x[0] ? X3_W'(3) : '0);
            r_yr     <= PRD_W'(i_pix.red) * K_Y_R;
            r_yg     <= PRD_W'(i_pix.green) * K_Y_G;
            r_yb     <= PRD_W'(i_pix.blue) * K_Y_B;
            r_cbr    <= PRD_W'(i_pix.red) * K_CB_R;
            r_cbg    <= PRD_W'(i_pix.green) * K_CB_G;
            r_half_b <= PRD_W'(i_pix.blue) * K_HALF;
            r_half_r <= PRD_W'(i_pix.red) * K_HALF;
            r_crg    <= PRD_W'(i_pix.green) * K_CR_G;
            r_crb    <= PRD_W'(i_pix.blue) * K_CR_B;
            r_a1     <= i_pix.opacity;
        end
    end

    assign row    = ADDR_W'(r_row);
    assign sum_y  = CSUM_W'(r_yr) + CSUM_W'(r_yg) + CSUM_W'(r_yb);
    assign sum_cb = K_C_OFF + CSUM_W'(r_half_b) - CSUM_W'(r_cbr) - CSUM_W'(r_cbg);
    assign sum_cr = K_C_OFF + CSUM_W'(r_half_r) - CSUM_W'(r_crg) - CSUM_W'(r_crb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_set.addr_y  <= row + ADDR_W'(r_x3) + ADDR_ONE;
            r_set.addr_a  <= row + ADDR_W'(r_x3) + ADDR_TWO;
            r_set.addr_cb <= row + ADDR_W'(r_ev3);
            r_set.addr_cr <= row + ADDR_W'(r_ev3) + ADDR_THREE;
            r_set.luma    <= sum_y[FRAC+BYTE_W-1:FRAC];
            r_set.alpha   <= r_a1;
            r_set.cb      <= sum_cb[FRAC+BYTE_W-1:FRAC];
            r_set.cr      <= sum_cr[FRAC+BYTE_W-1:FRAC];
        end
    end

    assign o_valid = r_v2;
    assign o_set   = r_set;

endmodule

// ===== rtl/rgbycc_ser.sv =====
`include "rgb_to_ycbcr422_alpha_pixel_writer_assert.svh"

module rgbycc_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rgbycc_pkg::t_wr_set i_set,
    rgbycc_wr_if.source         o_wr
);
    import rgbycc_pkg::*;

    logic              r_busy;
    t_slot             r_slot;
    t_wr_set           r_set;
    logic              r_ov;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_val;
    logic              r_last;

    logic              out_load, take, take_last, accept;
    logic [ADDR_W-1:0] sel_addr;
    logic [BYTE_W-1:0] sel_val;

    assign out_load  = !r_ov || o_wr.ready;
    assign take      = r_busy && out_load;
    assign take_last = take && (r_slot == SLOT_CR);
    assign o_ready   = !r_busy || take_last;
    assign accept    = i_valid && o_ready;

    always_comb begin
        case (r_slot)
            SLOT_LUMA: begin
                sel_addr = r_set.addr_y;
                sel_val  = r_set.luma;
            end
            SLOT_ALPHA: begin
                sel_addr = r_set.addr_a;
                sel_val  = r_set.alpha;
            end
            SLOT_CB: begin
                sel_addr = r_set.addr_cb;
                sel_val  = r_set.cb;
            end
            SLOT_CR: begin
                sel_addr = r_set.addr_cr;
                sel_val  = r_set.cr;
            end
            default: begin
                sel_addr = r_set.addr_y;
                sel_val  = r_set.luma;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SLOT_LUMA;
            r_ov   <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_slot <= SLOT_LUMA;
            end else if (take_last) begin
                r_busy <= 1'b0;
            end else if (take) begin
                r_slot <= t_slot'(r_slot + 2'd1);
            end
            if (out_load) begin
                r_ov <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= i_set;
        end
        if (out_load) begin
            r_addr <= sel_addr;
            r_val  <= sel_val;
            r_last <= (r_slot == SLOT_CR);
        end
    end

    assign o_wr.valid        = r_ov;
    assign o_wr.byte_address = r_addr;
    assign o_wr.byte_value   = r_val;
    assign o_wr.last_write   = r_last;

    `RGBYCC_ASSERT_RST(a_rst_clears, !i_rst_n |=> !r_ov && !r_busy, "reset left a word pending")
    `RGBYCC_ASSERT(a_last_flag, take_last |=> r_ov && r_last, "Cr word not flagged last")
    `RGBYCC_ASSERT(a_pair_addr, take_last |-> r_set.addr_cr == r_set.addr_cb + ADDR_THREE,
        "Cr address not one pixel past Cb")
    `RGBYCC_ASSERT(a_mid_hold, r_busy && r_slot != SLOT_CR |-> !o_ready, "pixel taken mid word set")

endmodule

// ===== rtl/rgb_to_ycbcr422_alpha_pixel_writer.sv =====
// RGB to YCbCr 4:2:2 pixel writer with alpha (BT.601, 16-bit fraction).
// Input channel i_pix: one pixel per word (coordinates, RGB, opacity),
// valid/ready handshake. Output channel o_wr: one framebuffer byte write per
// word; four words per pixel in the order luma, alpha, Cb, Cr, the Cr word
// carrying last_write. i_cfg_we/i_cfg_wdata load the row stride in bytes;
// write it only while the block is empty.
// The luma word of a pixel passes the products, sums, sequencer and output
// registers; the other three follow in order while o_wr.ready is high.
// Pixel rate is set by the byte-wide output channel (four words per pixel).
// Pipeline: products, sums, word sequencer, output register; the pixel
// stages keep filling while the sequencer works; it takes a new word set in
// the cycle the previous pixel's Cr word moves to the output register.
// Reset (synchronous, active low) empties all stages and sets the stride to
// 5760. When the receiver holds ready low the output word holds, the stages
// behind it fill up and then i_pix.ready drops; nothing is lost or repeated.
module rgb_to_ycbcr422_alpha_pixel_writer #(
    parameter int COORD_BITS = rgbycc_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rgbycc_pix_if.sink                      i_pix,
    rgbycc_wr_if.source                     o_wr,
    input  logic                            i_cfg_we,
    input  logic [rgbycc_pkg::STRIDE_W-1:0] i_cfg_wdata
);
    import rgbycc_pkg::*;

    logic [STRIDE_W-1:0] r_stride;
    logic                set_valid;
    logic                set_ready;
    t_wr_set             set_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RST;
        end else if (i_cfg_we) begin
            r_stride <= i_cfg_wdata;
        end
    end

    rgbycc_conv #(
        .COORD_BITS (COORD_BITS)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_stride (r_stride),
        .o_valid  (set_valid),
        .i_ready  (set_ready),
        .o_set    (set_data)
    );

    rgbycc_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (set_valid),
        .o_ready (set_ready),
        .i_set   (set_data),
        .o_wr    (o_wr)
    );

endmodule
